@@ rtl/core/sptach_pkg.sv @@
package sptach_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned RPM_W    = 26;
	localparam int unsigned IVL_W    = 16;
	localparam int unsigned STEP_W   = $clog2(TIME_W);

	localparam logic [TIME_W-1:0] USEC_PER_MINUTE = TIME_W'(60000000);
	localparam logic [IVL_W-1:0]  INTERVAL_RESET  = IVL_W'(1000);
	localparam logic [STEP_W-1:0] LAST_STEP       = STEP_W'(TIME_W - 1);

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_AVG,
		ST_DIV_RPM,
		ST_WAIT
	} state_t;

endpackage

@@ rtl/core/spark_period_tachometer.sv @@
// An item that does not close a window, or closes one with no sparks, loads
// the output register directly when it is free; one that closes a window with
// sparks first runs the avg divide and, for a nonzero avg, the rpm divide.
// One item per cycle between window closes while the output is not stalled; the
// shared 1-bit-per-cycle restoring divider sets the close cost. Reset (arst_n low)
// clears all state but the divider and output data; interval returns to 1000 ms.
module spark_period_tachometer (
	input  logic        clk,
	input  logic        arst_n,
	// config: update_interval_ms
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,  // [0] pin_level, [32:1] time_us, [64:33] time_ms, pad
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [25:0] rpm_value, [26] rpm_updated, pad
);
	import sptach_pkg::*;

	// field unpack
	logic              pin_level;
	logic [TIME_W-1:0] time_us;
	logic [TIME_W-1:0] time_ms;
	assign pin_level = s_tdata[0];
	assign time_us   = s_tdata[32:1];
	assign time_ms   = s_tdata[64:33];

	// architectural state
	logic [IVL_W-1:0]  interval_q;
	logic              pulse_q;
	logic [TIME_W-1:0] prev_spark_q;
	logic [TIME_W-1:0] spark_count_q;
	logic [TIME_W-1:0] interval_sum_q;
	logic [RPM_W-1:0]  rpm_q;
	logic [TIME_W-1:0] window_end_q;

	// sequencer / output
	state_t            state_q, state_d;
	logic              pend_upd_q;
	logic              m_tvalid_q;
	logic [RPM_W-1:0]  out_rpm_q;
	logic              out_upd_q;

	// shared divider
	logic [TIME_W-1:0] rem_q;
	logic [TIME_W-1:0] quo_q;
	logic [TIME_W-1:0] dvs_q;
	logic [STEP_W-1:0] step_q;
	logic [TIME_W+1:0] trial;
	logic              trial_ge;
	logic [TIME_W-1:0] rem_next;
	logic [TIME_W-1:0] quo_next;

	// control
	logic              in_acc;
	logic              rising;
	logic [TIME_W-1:0] cnt_new;
	logic [TIME_W-1:0] sum_new;
	logic              close;
	logic              out_free;
	logic              out_load;
	logic              out_upd_d;
	logic              div_start_avg;
	logic              div_start_rpm;
	logic              div_step;
	logic              rpm_load;

	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;

	// spark detect runs before the window check
	assign rising  = pin_level && !pulse_q;
	assign cnt_new = spark_count_q + {{(TIME_W-1){1'b0}}, rising};
	assign sum_new = rising ? (interval_sum_q + (time_us - prev_spark_q)) : interval_sum_q;
	assign close   = time_ms > window_end_q;  // plain unsigned compare

	assign out_free = !m_tvalid_q || m_tready;

	// restoring divide, one quotient bit per cycle
	assign trial    = {1'b0, rem_q, quo_q[TIME_W-1]} - {2'b00, dvs_q};
	assign trial_ge = !trial[TIME_W+1];
	assign rem_next = trial_ge ? trial[TIME_W-1:0] : {rem_q[TIME_W-2:0], quo_q[TIME_W-1]};
	assign quo_next = {quo_q[TIME_W-2:0], trial_ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		out_load      = 1'b0;
		out_upd_d     = pend_upd_q;
		div_start_avg = 1'b0;
		div_start_rpm = 1'b0;
		div_step      = 1'b0;
		rpm_load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (close && (cnt_new != '0)) begin
						div_start_avg = 1'b1;
						state_d       = ST_DIV_AVG;
					end else if (out_free) begin
						out_load  = 1'b1;
						out_upd_d = close;
					end else begin
						state_d = ST_WAIT;
					end
				end
			end
			ST_DIV_AVG: begin
				div_step = 1'b1;
				if (step_q == LAST_STEP) begin
					// zero average leaves rpm as is
					if (quo_next != '0) begin
						div_start_rpm = 1'b1;
						state_d       = ST_DIV_RPM;
					end else begin
						state_d = ST_WAIT;
					end
				end
			end
			ST_DIV_RPM: begin
				div_step = 1'b1;
				if (step_q == LAST_STEP) begin
					rpm_load = 1'b1;
					state_d  = ST_WAIT;
				end
			end
			ST_WAIT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// config and tachometer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q     <= INTERVAL_RESET;
			pulse_q        <= 1'b0;
			prev_spark_q   <= '0;
			spark_count_q  <= '0;
			interval_sum_q <= '0;
			rpm_q          <= '0;
			window_end_q   <= '0;
			pend_upd_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				interval_q <= cfg_data;
			end
			if (in_acc) begin
				pulse_q    <= pin_level;
				pend_upd_q <= close;
				if (rising) begin
					prev_spark_q <= time_us;
				end
				if (close) begin
					spark_count_q  <= '0;
					interval_sum_q <= '0;
					window_end_q   <= time_ms + {{(TIME_W-IVL_W){1'b0}}, interval_q};
				end else begin
					spark_count_q  <= cnt_new;
					interval_sum_q <= sum_new;
				end
			end
			if (rpm_load) begin
				rpm_q <= quo_next[RPM_W-1:0];
			end
		end
	end

	// divider step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (div_start_avg || div_start_rpm) begin
			step_q <= '0;
		end else if (div_step) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	// divider datapath: avg = sum / count, then rpm = 60e6 / avg
	always_ff @(posedge clk) begin
		if (div_start_avg) begin
			rem_q <= '0;
			quo_q <= sum_new;
			dvs_q <= cnt_new;
		end else if (div_start_rpm) begin
			rem_q <= '0;
			quo_q <= USEC_PER_MINUTE;
			dvs_q <= quo_next;
		end else if (div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rpm_q <= rpm_q;
			out_upd_q <= out_upd_d;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b00000, out_upd_q, out_rpm_q};

endmodule

@@ sim/tb_spark_period_tachometer.sv @@
`timescale 1ns / 100ps

module tb_spark_period_tachometer;

	import sptach_pkg::*;

	// Generous run limit: ~800 items, each at worst an avg and an rpm divide plus a
	// sender gap and a receiver stall, taken several times over.
	localparam int CYCLE_LIMIT = 400000;

	// Cycles allowed after the last result.
	localparam int TAIL_CYCLES = 80;

	typedef struct packed {
		logic [RPM_W-1:0] rpm;
		logic             updated;
	} rpm_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [15:0] cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;  // [0] pin_level, [32:1] time_us, [64:33] time_ms, pad
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;  // [25:0] rpm_value, [26] rpm_updated, pad

	// Shared between the sender and the receiver: random idling on or off.
	bit idle_on = 1'b1;

	int mismatch_count = 0;
	int cycle_count = 0;

	// Expected results, oldest first.
	rpm_result_t rpm_expect_q[$];

	// Shadow copy of the tachometer state and its interval register.
	logic [IVL_W-1:0]  interval_ms;
	logic              pulse_high;
	logic [TIME_W-1:0] last_spark_us;
	logic [TIME_W-1:0] sparks_in_window;
	logic [TIME_W-1:0] period_sum_us;
	logic [RPM_W-1:0]  rpm_now;
	logic [TIME_W-1:0] window_end_ms;

	spark_period_tachometer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Timeout watchdog.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Mismatches found");
		$finish;
	end

	function automatic void clear_tach_state();
		interval_ms      = INTERVAL_RESET;
		pulse_high       = 1'b0;
		last_spark_us    = '0;
		sparks_in_window = '0;
		period_sum_us    = '0;
		rpm_now          = '0;
		window_end_ms    = '0;
	endfunction

	// Advance the shadow state by one pin sample and return the result it gives.
	// Spark detection comes first, then the window check in the same item.
	function automatic rpm_result_t predict_rpm(input logic level,
			input logic [TIME_W-1:0] now_us, input logic [TIME_W-1:0] now_ms);
		rpm_result_t       res;
		logic [TIME_W-1:0] avg_us;
		res.updated = 1'b0;
		if (level) begin
			if (!pulse_high) begin
				pulse_high       = 1'b1;
				sparks_in_window = sparks_in_window + 1;
				period_sum_us    = period_sum_us + (now_us - last_spark_us);
				last_spark_us    = now_us;
			end
		end else begin
			pulse_high = 1'b0;
		end
		// plain unsigned compare, no wrap awareness
		if (now_ms > window_end_ms) begin
			res.updated = 1'b1;
			if (sparks_in_window != 0) begin
				avg_us = period_sum_us / sparks_in_window;
				// zero average keeps the previous RPM
				if (avg_us != 0)
					rpm_now = RPM_W'(USEC_PER_MINUTE / avg_us);
			end
			sparks_in_window = '0;
			period_sum_us    = '0;
			window_end_ms    = now_ms + TIME_W'(interval_ms);
		end
		res.rpm = rpm_now;
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatch_count++;
		$display("[%0t] MISMATCH %s: got 0x%08h, want 0x%08h", $time, what, got, want);
	endtask

	task automatic check_result(input logic [31:0] data);
		rpm_result_t want;
		if (rpm_expect_q.size() == 0) begin
			report_mismatch("result with nothing expected", data, 32'd0);
			return;
		end
		want = rpm_expect_q.pop_front();
		if (data[RPM_W-1:0] !== want.rpm)
			report_mismatch("rpm_value", 32'(data[RPM_W-1:0]), 32'(want.rpm));
		if (data[RPM_W] !== want.updated)
			report_mismatch("rpm_updated", 32'(data[RPM_W]), 32'(want.updated));
	endtask

	// Receiver: handshake seen at the negedge, taken at the next posedge.
	// m_tready is the only thing this process drives, once per posedge.
	initial begin : result_sink
		logic        seen_valid;
		logic        seen_ready;
		logic [31:0] seen_data;
		int          stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(negedge clk);
			seen_valid = m_tvalid;
			seen_ready = m_tready;
			seen_data  = m_tdata;
			@(posedge clk);
			if (seen_valid === 1'b1 && seen_ready === 1'b1)
				check_result(seen_data);
			if (idle_on && stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 19) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Send one pin sample. tvalid stays high on return so the next item can
	// follow back to back; an idle burst lowers it first.
	task automatic send_sample(input logic level, input logic [TIME_W-1:0] now_us,
			input logic [TIME_W-1:0] now_ms);
		logic ready_seen;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {7'd0, now_ms, now_us, level};
		do begin
			@(negedge clk);
			ready_seen = s_tready;
			@(posedge clk);
		end while (ready_seen !== 1'b1);
		rpm_expect_q.push_back(predict_rpm(level, now_us, now_ms));
	endtask

	// Hold off the sender until every expected result has come back.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (rpm_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Interval writes happen only with the block idle.
	task automatic write_interval(input logic [IVL_W-1:0] value);
		logic ready_seen;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do begin
			@(negedge clk);
			ready_seen = cfg_ready;
			@(posedge clk);
		end while (ready_seen !== 1'b1);
		cfg_valid <= 1'b0;
		interval_ms = value;
	endtask

	// Hand-picked samples: first spark from time zero, held pin, window close
	// with and without sparks, zero average, wrap of time and window end,
	// average of one microsecond (top RPM), interval sum wrap, interval extremes.
	task automatic test_directed();
		send_sample(1'b0, 32'd0, 32'd0);
		send_sample(1'b1, 32'd100, 32'd0);
		send_sample(1'b1, 32'd200, 32'd0);
		send_sample(1'b0, 32'd300, 32'd0);
		send_sample(1'b1, 32'd20100, 32'd1);
		send_sample(1'b0, 32'd20150, 32'd1);
		// spark at the same microsecond: zero average
		send_sample(1'b1, 32'd20100, 32'd1002);
		send_sample(1'b0, 32'd30000, 32'd5000);
		// all ones; window end wraps past zero
		send_sample(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_sample(1'b0, 32'd0, 32'd0);
		// one microsecond since the last spark
		send_sample(1'b1, 32'd0, 32'd1000);
		write_interval(16'hFFFF);
		send_sample(1'b0, 32'd5, 32'd1001);
		send_sample(1'b1, 32'h9000_0000, 32'd1500);
		send_sample(1'b0, 32'h9000_0001, 32'd1600);
		// two large periods: the interval sum wraps
		send_sample(1'b1, 32'h2000_0000, 32'd2001);
		send_sample(1'b0, 32'd10, 32'd2002);
		write_interval(16'd0);
		send_sample(1'b1, 32'd1000, 32'd67537);
		send_sample(1'b0, 32'd2000, 32'd67537);
		send_sample(1'b1, 32'd3000, 32'd67538);
		write_interval(16'd1);
		send_sample(1'b0, 32'd4000, 32'd67539);
		send_sample(1'b1, 32'd5000, 32'd67540);
		send_sample(1'b0, 32'd6000, 32'd67541);
	endtask

	// Engine-like pin waveform: each revolution is a few high samples then a
	// few low ones, times advancing together. Noise items carry random fields.
	task automatic run_engine(input int n_items, input logic [IVL_W-1:0] interval,
			input bit with_noise);
		logic [TIME_W-1:0] now_us;
		logic [TIME_W-1:0] now_ms;
		int unsigned       frac_us;
		int unsigned       period_us;
		int unsigned       step_us;
		int                hi_cnt;
		int                lo_cnt;
		int                sent;
		write_interval(interval);
		// start just ahead of the pending window end so windows close soon
		now_ms    = window_end_ms - TIME_W'($urandom_range(0, 2));
		now_us    = $urandom;
		frac_us   = 0;
		period_us = $urandom_range(600, 60000);
		sent      = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 15) == 0)
				period_us = $urandom_range(300, 60000);
			hi_cnt  = $urandom_range(1, 3);
			lo_cnt  = $urandom_range(1, 4);
			step_us = period_us / (hi_cnt + lo_cnt) + $urandom_range(0, 20);
			for (int k = 0; k < hi_cnt + lo_cnt && sent < n_items; k++) begin
				now_us  = now_us + step_us;
				frac_us = frac_us + step_us;
				now_ms  = now_ms + frac_us / 1000;
				frac_us = frac_us % 1000;
				if (with_noise && $urandom_range(0, 9) == 0)
					send_sample(1'($urandom_range(0, 1)), $urandom, $urandom);
				else
					send_sample(k < hi_cnt, now_us, now_ms);
				sent++;
			end
		end
	endtask

	task automatic test_short_windows();
		run_engine(150, 16'd1, 1'b1);
		run_engine(150, 16'd3, 1'b0);
	endtask

	task automatic test_random_interval();
		run_engine(80, 16'($urandom_range(1, 50)), 1'b1);
		// sender waits for every result, then carries on with a new random interval
		drain_results();
		run_engine(70, 16'($urandom_range(1, 50)), 1'b1);
	endtask

	task automatic test_interval_extremes();
		run_engine(60, 16'hFFFF, 1'b0);
		run_engine(100, 16'd0, 1'b1);
	endtask

	// Last part: no idling on either side, full rate.
	task automatic test_full_rate();
		idle_on = 1'b0;
		run_engine(170, 16'($urandom_range(1, 20)), 1'b1);
	endtask

	initial begin
		clear_tach_state();
		arst_n    <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_short_windows();
		test_random_interval();
		test_interval_extremes();
		test_full_rate();

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
